>>> rtl/avr_instruction_decoder_top_assert.svh
// Assertion macros for the AVR instruction decoder top level.
// Included by the top level only; no other dependencies.
`ifndef AVR_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define AVR_INSTRUCTION_DECODER_TOP_ASSERT_SVH
// Property that must hold at every clock edge outside reset.
`define AVRD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Property checked in the cycle after its trigger.
`define AVRD_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);
`endif

>>> rtl/avrd_pkg.sv
// Shared types, mnemonic codes and the decode function for the AVR instruction decoder.
// No dependencies.
package avrd_pkg;

	localparam logic [6:0] MN_NONE  = 7'd0;
	localparam logic [6:0] MN_LDS   = 7'd1;
	localparam logic [6:0] MN_STS   = 7'd2;
	localparam logic [6:0] MN_JMP   = 7'd3;
	localparam logic [6:0] MN_CALL  = 7'd4;
	localparam logic [6:0] MN_BRCS  = 7'd49;
	localparam logic [6:0] MN_LDD   = 7'd81;
	localparam logic [6:0] MN_STD   = 7'd82;
	localparam logic [6:0] MN_LD    = 7'd83;
	localparam logic [6:0] MN_RCALL = 7'd84;
	localparam logic [6:0] MN_RJMP  = 7'd85;
	localparam logic [6:0] MN_IN    = 7'd86;
	localparam logic [6:0] MN_OUT   = 7'd87;
	localparam logic [6:0] MN_ADIW  = 7'd100;
	localparam logic [6:0] MN_SBIW  = 7'd101;
	localparam logic [6:0] MN_MULSU = 7'd102;
	localparam logic [6:0] MN_MOVW  = 7'd106;
	localparam logic [6:0] MN_MULS  = 7'd107;

	localparam logic [1:0] PR_NONE = 2'd0;
	localparam logic [1:0] PR_X    = 2'd1;
	localparam logic [1:0] PR_Y    = 2'd2;
	localparam logic [1:0] PR_Z    = 2'd3;
	localparam logic [1:0] PM_PLAIN = 2'd0;
	localparam logic [1:0] PM_INC   = 2'd1;
	localparam logic [1:0] PM_DEC   = 2'd2;
	localparam logic [1:0] PM_DISP  = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	// Word as classified by the front end.
	typedef struct packed {
		logic [15:0] addr;
		logic [15:0] op;
		logic [15:0] second;
		logic        two_word;
	} fetch_t;

	typedef struct packed {
		logic [15:0] instr_address;
		logic [6:0]  mnemonic;
		logic [4:0]  dst_reg;
		logic [4:0]  src_reg;
		logic [1:0]  pointer_reg;
		logic [1:0]  pointer_mode;
		logic [5:0]  displacement;
		logic [7:0]  immediate;
		logic [22:0] target_address;
		logic        two_word;
		logic        shows_flags;
		logic        recognized;
	} result_t;

	function automatic logic is_first_of_pair(input logic [15:0] w);
		return ((w & 16'hFE0F) == 16'h9000) || ((w & 16'hFE0F) == 16'h9200) ||
			((w & 16'hFE0C) == 16'h940C);
	endfunction

	function automatic logic [6:0] noarg_mn(input logic [15:0] op);
		logic [6:0] m;
		m = MN_NONE;
		case (op)
			16'h9598: m = 7'd5;   16'h9488: m = 7'd6;   16'h94D8: m = 7'd7;
			16'h94F8: m = 7'd8;   16'h94A8: m = 7'd9;   16'h94C8: m = 7'd10;
			16'h94E8: m = 7'd11;  16'h94B8: m = 7'd12;  16'h9498: m = 7'd13;
			16'h9519: m = 7'd14;  16'h9419: m = 7'd15;  16'h95D8: m = 7'd16;
			16'h9509: m = 7'd17;  16'h9409: m = 7'd18;  16'h95C8: m = 7'd19;
			16'h0000: m = 7'd20;  16'h9508: m = 7'd21;  16'h9518: m = 7'd22;
			16'h9408: m = 7'd23;  16'h9458: m = 7'd24;  16'h9478: m = 7'd25;
			16'h9428: m = 7'd26;  16'h9448: m = 7'd27;  16'h9468: m = 7'd28;
			16'h9438: m = 7'd29;  16'h9418: m = 7'd30;  16'h9588: m = 7'd31;
			16'h95E8: m = 7'd32;  16'h95F8: m = 7'd32;  16'h95A8: m = 7'd33;
			default: m = MN_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [6:0] logic_mn(input logic [15:0] op);
		logic [6:0] m;
		case (op & 16'hFE0F)
			16'h900F: m = 7'd34;  16'h920F: m = 7'd35;  16'h9400: m = 7'd36;
			16'h9401: m = 7'd37;  16'h9402: m = 7'd38;  16'h9403: m = 7'd39;
			16'h9405: m = 7'd40;  16'h9406: m = 7'd41;  16'h9407: m = 7'd42;
			16'h940A: m = 7'd43;
			default: m = MN_NONE;
		endcase
		return m;
	endfunction

	// Mnemonic, pointer and mode packed together for the pointer forms.
	function automatic logic [10:0] store_form(input logic [15:0] op);
		logic [10:0] r;
		case (op & 16'hFE0F)
			16'h9204: r = {7'd44, PR_Z, PM_PLAIN};
			16'h9205: r = {7'd45, PR_Z, PM_PLAIN};
			16'h9206: r = {7'd46, PR_Z, PM_PLAIN};
			16'h9207: r = {7'd47, PR_Z, PM_PLAIN};
			16'h920C: r = {7'd48, PR_X, PM_PLAIN};
			16'h920D: r = {7'd48, PR_X, PM_INC};
			16'h920E: r = {7'd48, PR_X, PM_DEC};
			16'h8208: r = {7'd48, PR_Y, PM_PLAIN};
			16'h9209: r = {7'd48, PR_Y, PM_INC};
			16'h920A: r = {7'd48, PR_Y, PM_DEC};
			16'h8200: r = {7'd48, PR_Z, PM_PLAIN};
			16'h9201: r = {7'd48, PR_Z, PM_INC};
			16'h9202: r = {7'd48, PR_Z, PM_DEC};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [10:0] load_form(input logic [15:0] op);
		logic [10:0] r;
		case (op & 16'hFE0F)
			16'h9004: r = {7'd19, PR_Z, PM_PLAIN};
			16'h9005: r = {7'd19, PR_Z, PM_INC};
			16'h9006: r = {7'd16, PR_Z, PM_PLAIN};
			16'h9007: r = {7'd16, PR_Z, PM_INC};
			16'h900C: r = {MN_LD, PR_X, PM_PLAIN};
			16'h900D: r = {MN_LD, PR_X, PM_INC};
			16'h900E: r = {MN_LD, PR_X, PM_DEC};
			16'h8008: r = {MN_LD, PR_Y, PM_PLAIN};
			16'h9009: r = {MN_LD, PR_Y, PM_INC};
			16'h900A: r = {MN_LD, PR_Y, PM_DEC};
			16'h8000: r = {MN_LD, PR_Z, PM_PLAIN};
			16'h9001: r = {MN_LD, PR_Z, PM_INC};
			16'h9002: r = {MN_LD, PR_Z, PM_DEC};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] arith_mn(input logic [15:0] op);
		logic [6:0] m;
		case (op & 16'hFC00)
			16'h1C00: m = 7'd65;  16'h0C00: m = 7'd66;  16'h2000: m = 7'd67;
			16'h1400: m = 7'd68;  16'h0400: m = 7'd69;  16'h1000: m = 7'd70;
			16'h2400: m = 7'd71;  16'h2C00: m = 7'd72;  16'h9C00: m = 7'd73;
			16'h2800: m = 7'd74;  16'h0800: m = 7'd75;  16'h1800: m = 7'd76;
			default: m = MN_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [6:0] byteimd_mn(input logic [15:0] op);
		logic [6:0] m;
		case (op[15:12])
			4'h3: m = 7'd88;  4'h4: m = 7'd89;  4'h5: m = 7'd90;
			4'h6: m = 7'd91;  4'h7: m = 7'd92;  4'hE: m = 7'd93;
			default: m = MN_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [6:0] bitreg_mn(input logic [15:0] op);
		logic [6:0] m;
		case (op & 16'hFE08)
			16'hF800: m = 7'd77;  16'hFA00: m = 7'd78;
			16'hFC00: m = 7'd79;  16'hFE00: m = 7'd80;
			default: m = MN_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [6:0] iobit_mn(input logic [15:0] op);
		logic [6:0] m;
		case (op[15:8])
			8'h98: m = 7'd96;  8'h9A: m = 7'd97;  8'h99: m = 7'd98;  8'h9B: m = 7'd99;
			default: m = MN_NONE;
		endcase
		return m;
	endfunction

	// Full decode of one classified item.
	function automatic result_t decode(input fetch_t f);
		result_t     r;
		logic [15:0] op;
		logic [15:0] a;
		logic [4:0]  d5;
		logic [10:0] pf;
		logic [15:0] m;
		logic [15:0] boff;
		logic [15:0] roff;
		op   = f.op;
		a    = f.addr;
		d5   = op[8:4];
		m    = op & 16'hD208;
		boff = {{8{op[9]}}, op[9:3], 1'b0};
		roff = {{3{op[11]}}, op[11:0], 1'b0};
		r    = '0;
		r.instr_address = a;
		if (f.two_word) begin
			r.two_word = 1'b1;
			if ((op & 16'hFE0F) == 16'h9000) begin
				r.mnemonic = MN_LDS;
				r.dst_reg = d5;
				r.target_address = {7'd0, f.second};
			end else if ((op & 16'hFE0F) == 16'h9200) begin
				r.mnemonic = MN_STS;
				r.src_reg = d5;
				r.target_address = {7'd0, f.second};
			end else begin
				r.mnemonic = op[1] ? MN_CALL : MN_JMP;
				r.target_address = {op[8:4], op[0], f.second, 1'b0};
			end
		end else if (noarg_mn(op) != MN_NONE) begin
			r.mnemonic = noarg_mn(op);
		end else if (logic_mn(op) != MN_NONE) begin
			r.mnemonic = logic_mn(op);
			r.dst_reg = d5;
		end else if (store_form(op) != '0) begin
			pf = store_form(op);
			{r.mnemonic, r.pointer_reg, r.pointer_mode} = pf;
			r.src_reg = d5;
		end else if (op[15:11] == 5'b11110) begin
			r.mnemonic = MN_BRCS + {3'd0, op[10], op[2:0]};
			r.target_address = {7'd0, a + boff + 16'd2};
			r.immediate = {5'd0, op[2:0]};
			r.shows_flags = 1'b1;
		end else if (arith_mn(op) != MN_NONE) begin
			r.mnemonic = arith_mn(op);
			r.dst_reg = d5;
			r.src_reg = {op[9], op[3:0]};
		end else if (bitreg_mn(op) != MN_NONE) begin
			r.mnemonic = bitreg_mn(op);
			r.dst_reg = d5;
			r.immediate = {5'd0, op[2:0]};
		end else if (m == 16'h8008 || m == 16'h8000 || m == 16'h8208 || m == 16'h8200) begin
			r.mnemonic = m[9] ? MN_STD : MN_LDD;
			r.pointer_reg = m[3] ? PR_Y : PR_Z;
			r.pointer_mode = PM_DISP;
			r.displacement = {op[13], op[11:10], op[2:0]};
			r.dst_reg = d5;
		end else if (load_form(op) != '0) begin
			pf = load_form(op);
			{r.mnemonic, r.pointer_reg, r.pointer_mode} = pf;
			r.dst_reg = d5;
		end else if (op[15:13] == 3'b110) begin
			r.mnemonic = op[12] ? MN_RCALL : MN_RJMP;
			r.target_address = {7'd0, a + roff + 16'd2};
		end else if (op[15:12] == 4'hB) begin
			r.immediate = {2'd0, op[10:9], op[3:0]};
			if (op[11]) begin
				r.mnemonic = MN_OUT;
				r.src_reg = d5;
			end else begin
				r.mnemonic = MN_IN;
				r.dst_reg = d5;
			end
		end else if (byteimd_mn(op) != MN_NONE) begin
			r.mnemonic = byteimd_mn(op);
			r.dst_reg = {1'b1, op[7:4]};
			r.immediate = {op[11:8], op[3:0]};
		end else if (iobit_mn(op) != MN_NONE) begin
			r.mnemonic = iobit_mn(op);
			r.immediate = {3'd0, op[7:3]};
			r.displacement = {3'd0, op[2:0]};
		end else if (op[15:9] == 7'b1001011) begin
			r.mnemonic = op[8] ? MN_SBIW : MN_ADIW;
			r.dst_reg = {2'b11, op[5:4], 1'b0};
			r.immediate = {2'd0, op[7:6], op[3:0]};
		end else if (op[15:8] == 8'h03) begin
			r.mnemonic = MN_MULSU + {5'd0, op[7], op[3]};
			r.dst_reg = {2'b10, op[6:4]};
			r.src_reg = {2'b10, op[2:0]};
		end else if (op[15:8] == 8'h01) begin
			r.mnemonic = MN_MOVW;
			r.dst_reg = {op[7:4], 1'b0};
			r.src_reg = {op[3:0], 1'b0};
		end else if (op[15:8] == 8'h02) begin
			r.mnemonic = MN_MULS;
			r.dst_reg = {1'b1, op[7:4]};
			r.src_reg = {1'b1, op[3:0]};
		end
		r.recognized = (r.mnemonic != MN_NONE);
		return r;
	endfunction

endpackage

>>> rtl/avrd_front.sv
// Front end: accepts program words, pairs two-word instructions, emits classified items.
// Depends on avrd_pkg.
module avrd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [15:0]          word_address,
	input  logic [15:0]          instruction_word,
	output logic                 item_valid,
	input  logic                 item_ready,
	output avrd_pkg::fetch_t     item
);
	import avrd_pkg::*;

	logic        awaiting_q;
	logic [15:0] held_op_q;
	logic [15:0] held_addr_q;
	logic        valid_s1;
	fetch_t      item_s1;
	logic        take;
	logic        first;

	// A slot is free when the stage is empty or is being drained this cycle.
	assign full  = valid_s1 && !item_ready;
	assign take  = push && !full;
	assign first = !awaiting_q && is_first_of_pair(instruction_word);
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b0;
			held_op_q   <= '0;
			held_addr_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= (valid_s1 && !item_ready) || (take && !first);
			if (take) begin
				if (first) begin
					awaiting_q  <= 1'b1;
					held_op_q   <= instruction_word;
					held_addr_q <= word_address;
				end else begin
					awaiting_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !first) begin
			item_s1.two_word <= awaiting_q;
			item_s1.op       <= awaiting_q ? held_op_q : instruction_word;
			item_s1.addr     <= awaiting_q ? held_addr_q : word_address;
			item_s1.second   <= instruction_word;
		end
	end
endmodule

>>> rtl/avrd_queue.sv
// Two-entry queue between the front and back ends of the decoder.
// Depends on avrd_pkg.
module avrd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  avrd_pkg::fetch_t wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output avrd_pkg::fetch_t rd_data
);
	import avrd_pkg::*;

	fetch_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q;
	logic [QUEUE_AW-1:0] rp_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                wr;
	logic                rd;

	assign wr_ready = (cnt_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + QUEUE_AW'(1);
			if (rd)
				rp_q <= rp_q + QUEUE_AW'(1);
			if (wr && !rd)
				cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
			else if (rd && !wr)
				cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end
endmodule

>>> rtl/avrd_back.sv
// Back end: decodes a classified item into its fields and holds the result register.
// Depends on avrd_pkg.
module avrd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  avrd_pkg::fetch_t  item,
	output logic              empty,
	input  logic              pop,
	output avrd_pkg::result_t res
);
	import avrd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign empty = !valid_q;
	assign item_ready = !valid_q || pop;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (item_ready)
			valid_q <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			res_q <= decode(item);
	end
endmodule

>>> rtl/avr_instruction_decoder_top.sv
// AVR instruction decoder top level: front end, queue and back end.
// Depends on avrd_pkg, avrd_front, avrd_queue, avrd_back and the assertion header.
//
// Takes one program word per cycle while full is low and returns one decoded instruction per
// cycle while pop is held high. The first word of lds, sts, jmp or call gives no result; the
// result appears once its second word is taken. An accepted word passes through the front
// register, then the queue and then the decode register, which drives the result ports.
module avr_instruction_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] word_address,
	input  logic [15:0] instruction_word,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] instr_address,
	output logic [6:0]  mnemonic,
	output logic [4:0]  dst_reg,
	output logic [4:0]  src_reg,
	output logic [1:0]  pointer_reg,
	output logic [1:0]  pointer_mode,
	output logic [5:0]  displacement,
	output logic [7:0]  immediate,
	output logic [22:0] target_address,
	output logic        two_word,
	output logic        shows_flags,
	output logic        recognized
);
	import avrd_pkg::*;
	`include "avr_instruction_decoder_top_assert.svh"

	logic    f_valid;
	logic    f_ready;
	fetch_t  f_item;
	logic    b_valid;
	logic    b_ready;
	fetch_t  b_item;
	result_t res;

	avrd_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.word_address(word_address), .instruction_word(instruction_word),
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	avrd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_item)
	);

	avrd_back u_back (
		.clk(clk), .arst_n(arst_n), .item_valid(b_valid), .item_ready(b_ready),
		.item(b_item), .empty(empty), .pop(pop), .res(res)
	);

	assign instr_address  = res.instr_address;
	assign mnemonic       = res.mnemonic;
	assign dst_reg        = res.dst_reg;
	assign src_reg        = res.src_reg;
	assign pointer_reg    = res.pointer_reg;
	assign pointer_mode   = res.pointer_mode;
	assign displacement   = res.displacement;
	assign immediate      = res.immediate;
	assign target_address = res.target_address;
	assign two_word       = res.two_word;
	assign shows_flags    = res.shows_flags;
	assign recognized     = res.recognized;

	`AVRD_ASSERT(a_recog_match, empty || (recognized == (mnemonic != MN_NONE)), "recognized flag disagrees with mnemonic")
	`AVRD_ASSERT(a_two_word_mn, empty || (two_word == (mnemonic == MN_LDS || mnemonic == MN_STS || mnemonic == MN_JMP || mnemonic == MN_CALL)), "two_word flag disagrees with mnemonic")
	`AVRD_ASSERT_NEXT(a_queue_moves, b_valid && b_ready, !empty, "queued item lost before the result register")
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the AVR instruction decoder top level.
// Depends on avrd_pkg and avr_instruction_decoder_top; drives program words, checks decodes.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import avrd_pkg::*;

	typedef struct packed {
		logic [15:0] addr;
		logic [15:0] word;
	} fetch_req_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [15:0] word_address;
	logic [15:0] instruction_word;
	logic        empty;
	logic        pop;
	result_t     got;

	fetch_req_t  pending_words[$];
	result_t     expected_decodes[$];
	int          mismatches;
	bit          calm;
	bit          hold_results;
	int          results_seen;

	// Predictor state: the first word of a two-word instruction.
	bit          pair_open;
	logic [15:0] pair_opcode;
	logic [15:0] pair_addr;

	// Handshake outcomes captured at the rising edge.
	logic        full_at_edge;

	avr_instruction_decoder_top i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.word_address(word_address), .instruction_word(instruction_word),
		.empty(empty), .pop(pop),
		.instr_address(got.instr_address), .mnemonic(got.mnemonic),
		.dst_reg(got.dst_reg), .src_reg(got.src_reg),
		.pointer_reg(got.pointer_reg), .pointer_mode(got.pointer_mode),
		.displacement(got.displacement), .immediate(got.immediate),
		.target_address(got.target_address), .two_word(got.two_word),
		.shows_flags(got.shows_flags), .recognized(got.recognized)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [6:0] exact_code(input logic [15:0] w);
		case (w)
			16'h9598: return 7'd5;   16'h9488: return 7'd6;   16'h94D8: return 7'd7;
			16'h94F8: return 7'd8;   16'h94A8: return 7'd9;   16'h94C8: return 7'd10;
			16'h94E8: return 7'd11;  16'h94B8: return 7'd12;  16'h9498: return 7'd13;
			16'h9519: return 7'd14;  16'h9419: return 7'd15;  16'h95D8: return 7'd16;
			16'h9509: return 7'd17;  16'h9409: return 7'd18;  16'h95C8: return 7'd19;
			16'h0000: return 7'd20;  16'h9508: return 7'd21;  16'h9518: return 7'd22;
			16'h9408: return 7'd23;  16'h9458: return 7'd24;  16'h9478: return 7'd25;
			16'h9428: return 7'd26;  16'h9448: return 7'd27;  16'h9468: return 7'd28;
			16'h9438: return 7'd29;  16'h9418: return 7'd30;  16'h9588: return 7'd31;
			16'h95E8: return 7'd32;  16'h95F8: return 7'd32;  16'h95A8: return 7'd33;
			default: return MN_NONE;
		endcase
	endfunction

	// Decodes one single-word instruction into the result fields.
	function automatic result_t decode_word(input logic [15:0] a, input logic [15:0] w);
		result_t     r;
		logic [4:0]  d5;
		logic [15:0] m;
		logic [15:0] ofs;
		logic [15:0] tgt;
		r = '0;
		d5 = w[8:4];
		m = w & 16'hD208;
		r.instr_address = a;
		r.mnemonic = exact_code(w);
		if (r.mnemonic != MN_NONE) begin
			r.recognized = 1'b1;
			return r;
		end
		case (w & 16'hFE0F)
			16'h900F: r.mnemonic = 7'd34;  16'h920F: r.mnemonic = 7'd35;
			16'h9400: r.mnemonic = 7'd36;  16'h9401: r.mnemonic = 7'd37;
			16'h9402: r.mnemonic = 7'd38;  16'h9403: r.mnemonic = 7'd39;
			16'h9405: r.mnemonic = 7'd40;  16'h9406: r.mnemonic = 7'd41;
			16'h9407: r.mnemonic = 7'd42;  16'h940A: r.mnemonic = 7'd43;
			default: ;
		endcase
		if (r.mnemonic != MN_NONE) begin
			r.dst_reg = d5;
		end else begin
			case (w & 16'hFE0F)
				16'h9204: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd44, PR_Z, PM_PLAIN};
				16'h9205: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd45, PR_Z, PM_PLAIN};
				16'h9206: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd46, PR_Z, PM_PLAIN};
				16'h9207: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd47, PR_Z, PM_PLAIN};
				16'h920C: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_X, PM_PLAIN};
				16'h920D: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_X, PM_INC};
				16'h920E: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_X, PM_DEC};
				16'h8208: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_Y, PM_PLAIN};
				16'h9209: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_Y, PM_INC};
				16'h920A: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_Y, PM_DEC};
				16'h8200: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_Z, PM_PLAIN};
				16'h9201: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_Z, PM_INC};
				16'h9202: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd48, PR_Z, PM_DEC};
				default: ;
			endcase
			if (r.mnemonic != MN_NONE) begin
				r.src_reg = d5;
			end else if (w[15:11] == 5'b11110) begin
				// The branch target wraps within the 16-bit address space.
				ofs = {{8{w[9]}}, w[9:3], 1'b0};
				tgt = a + ofs + 16'd2;
				r.mnemonic = MN_BRCS + (w[10] ? 7'd8 : 7'd0) + {4'd0, w[2:0]};
				r.target_address = {7'd0, tgt};
				r.immediate = {5'd0, w[2:0]};
				r.shows_flags = 1'b1;
			end else begin
				case (w & 16'hFC00)
					16'h1C00: r.mnemonic = 7'd65;  16'h0C00: r.mnemonic = 7'd66;
					16'h2000: r.mnemonic = 7'd67;  16'h1400: r.mnemonic = 7'd68;
					16'h0400: r.mnemonic = 7'd69;  16'h1000: r.mnemonic = 7'd70;
					16'h2400: r.mnemonic = 7'd71;  16'h2C00: r.mnemonic = 7'd72;
					16'h9C00: r.mnemonic = 7'd73;  16'h2800: r.mnemonic = 7'd74;
					16'h0800: r.mnemonic = 7'd75;  16'h1800: r.mnemonic = 7'd76;
					default: ;
				endcase
				if (r.mnemonic != MN_NONE) begin
					r.dst_reg = d5;
					r.src_reg = {w[9], w[3:0]};
				end else begin
					case (w & 16'hFE08)
						16'hF800: r.mnemonic = 7'd77;  16'hFA00: r.mnemonic = 7'd78;
						16'hFC00: r.mnemonic = 7'd79;  16'hFE00: r.mnemonic = 7'd80;
						default: ;
					endcase
					if (r.mnemonic != MN_NONE) begin
						r.dst_reg = d5;
						r.immediate = {5'd0, w[2:0]};
					end else if (m == 16'h8008 || m == 16'h8000 || m == 16'h8208 ||
							m == 16'h8200) begin
						r.mnemonic = m[9] ? MN_STD : MN_LDD;
						r.pointer_reg = m[3] ? PR_Y : PR_Z;
						r.pointer_mode = PM_DISP;
						r.displacement = {w[13], w[11:10], w[2:0]};
						r.dst_reg = d5;
					end else begin
						case (w & 16'hFE0F)
							16'h9004: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd19, PR_Z, PM_PLAIN};
							16'h9005: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd19, PR_Z, PM_INC};
							16'h9006: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd16, PR_Z, PM_PLAIN};
							16'h9007: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {7'd16, PR_Z, PM_INC};
							16'h900C: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_X, PM_PLAIN};
							16'h900D: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_X, PM_INC};
							16'h900E: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_X, PM_DEC};
							16'h8008: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_Y, PM_PLAIN};
							16'h9009: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_Y, PM_INC};
							16'h900A: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_Y, PM_DEC};
							16'h8000: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_Z, PM_PLAIN};
							16'h9001: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_Z, PM_INC};
							16'h9002: {r.mnemonic, r.pointer_reg, r.pointer_mode} = {MN_LD, PR_Z, PM_DEC};
							default: ;
						endcase
						if (r.mnemonic != MN_NONE) begin
							r.dst_reg = d5;
						end else if (w[15:13] == 3'b110) begin
							ofs = {{3{w[11]}}, w[11:0], 1'b0};
							tgt = a + ofs + 16'd2;
							r.mnemonic = w[12] ? MN_RCALL : MN_RJMP;
							r.target_address = {7'd0, tgt};
						end else if (w[15:12] == 4'hB) begin
							r.immediate = {2'd0, w[10:9], w[3:0]};
							if (w[11]) begin
								r.mnemonic = MN_OUT;
								r.src_reg = d5;
							end else begin
								r.mnemonic = MN_IN;
								r.dst_reg = d5;
							end
						end else if (w[15:12] inside {4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE}) begin
							case (w[15:12])
								4'h3: r.mnemonic = 7'd88;  4'h4: r.mnemonic = 7'd89;
								4'h5: r.mnemonic = 7'd90;  4'h6: r.mnemonic = 7'd91;
								4'h7: r.mnemonic = 7'd92;  default: r.mnemonic = 7'd93;
							endcase
							r.dst_reg = {1'b1, w[7:4]};
							r.immediate = {w[11:8], w[3:0]};
						end else if (w[15:8] inside {8'h98, 8'h99, 8'h9A, 8'h9B}) begin
							case (w[15:8])
								8'h98: r.mnemonic = 7'd96;  8'h9A: r.mnemonic = 7'd97;
								8'h99: r.mnemonic = 7'd98;  default: r.mnemonic = 7'd99;
							endcase
							r.immediate = {3'd0, w[7:3]};
							r.displacement = {3'd0, w[2:0]};
						end else if (w[15:9] == 7'b1001011) begin
							r.mnemonic = w[8] ? MN_SBIW : MN_ADIW;
							r.dst_reg = 5'd24 + {2'd0, w[5:4], 1'b0};
							r.immediate = {2'd0, w[7:6], w[3:0]};
						end else if (w[15:8] == 8'h03) begin
							r.mnemonic = MN_MULSU + (w[7] ? 7'd2 : 7'd0) + (w[3] ? 7'd1 : 7'd0);
							r.dst_reg = {2'b10, w[6:4]};
							r.src_reg = {2'b10, w[2:0]};
						end else if (w[15:8] == 8'h01) begin
							r.mnemonic = MN_MOVW;
							r.dst_reg = {w[7:4], 1'b0};
							r.src_reg = {w[3:0], 1'b0};
						end else if (w[15:8] == 8'h02) begin
							r.mnemonic = MN_MULS;
							r.dst_reg = {1'b1, w[7:4]};
							r.src_reg = {1'b1, w[3:0]};
						end
					end
				end
			end
		end
		r.recognized = (r.mnemonic != MN_NONE);
		return r;
	endfunction

	// Runs the decoder model on one accepted request.
	task automatic predict_decode(input fetch_req_t q);
		result_t    r;
		logic [4:0] d5;
		r = '0;
		if (pair_open) begin
			pair_open = 1'b0;
			d5 = pair_opcode[8:4];
			r.instr_address = pair_addr;
			r.two_word = 1'b1;
			r.recognized = 1'b1;
			if ((pair_opcode & 16'hFE0F) == 16'h9000) begin
				r.mnemonic = MN_LDS;
				r.dst_reg = d5;
				r.target_address = {7'd0, q.word};
			end else if ((pair_opcode & 16'hFE0F) == 16'h9200) begin
				r.mnemonic = MN_STS;
				r.src_reg = d5;
				r.target_address = {7'd0, q.word};
			end else begin
				r.mnemonic = pair_opcode[1] ? MN_CALL : MN_JMP;
				r.target_address = {pair_opcode[8:4], pair_opcode[0], q.word, 1'b0};
			end
			expected_decodes.push_back(r);
		end else if ((q.word & 16'hFE0F) == 16'h9000 || (q.word & 16'hFE0F) == 16'h9200 ||
				(q.word & 16'hFE0C) == 16'h940C) begin
			pair_open = 1'b1;
			pair_opcode = q.word;
			pair_addr = q.addr;
		end else begin
			expected_decodes.push_back(decode_word(q.addr, q.word));
		end
	endtask

	function automatic logic [15:0] exact_code_pick();
		logic [15:0] codes[30];
		codes = '{16'h9598, 16'h9488, 16'h94D8, 16'h94F8, 16'h94A8, 16'h94C8, 16'h94E8,
			16'h94B8, 16'h9498, 16'h9519, 16'h9419, 16'h95D8, 16'h9509, 16'h9409, 16'h95C8,
			16'h0000, 16'h9508, 16'h9518, 16'h9408, 16'h9458, 16'h9478, 16'h9428, 16'h9448,
			16'h9468, 16'h9438, 16'h9418, 16'h9588, 16'h95E8, 16'h95F8, 16'h95A8};
		return codes[$urandom_range(0, 29)];
	endfunction

	function automatic logic [15:0] random_opcode();
		logic [15:0] w;
		int          pick;
		w = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 8)
			w = exact_code_pick();
		else if (pick < 16)
			w = (w & 16'h01F3) | 16'h940C;
		else if (pick < 22)
			w = (w & 16'h01F0) | (($urandom_range(0, 1)) ? 16'h9000 : 16'h9200);
		else if (pick < 40)
			w = (w & 16'h0FFF) | 16'h9000;
		else if (pick < 50)
			w = (w & 16'h0FFF) | 16'h8000;
		else if (pick < 58)
			w = {6'd0, 2'($urandom_range(1, 3)), w[7:0]};
		return w;
	endfunction

	task automatic queue_word(input logic [15:0] a, input logic [15:0] w);
		pending_words.push_back('{addr: a, word: w});
	endtask

	// Driver: offers queued requests, idles in random bursts.
	int idle_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			word_address <= '0;
			instruction_word <= '0;
			idle_left <= 0;
		end else begin
			if (push && !full_at_edge) begin
				predict_decode('{addr: word_address, word: instruction_word});
				void'(pending_words.pop_front());
			end
			if (idle_left > 0) begin
				idle_left <= idle_left - 1;
				push <= 1'b0;
			end else if (!calm && !(push && full_at_edge) && $urandom_range(0, 19) == 0) begin
				idle_left <= $urandom_range(1, 12);
				push <= 1'b0;
			end else if (pending_words.size() > 0) begin
				push <= 1'b1;
				word_address <= pending_words[0].addr;
				instruction_word <= pending_words[0].word;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) full_at_edge <= full;

	// Monitor: checks every accepted decode against the oldest expectation.
	int pop_idle;
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			results_seen <= results_seen + 1;
			if (expected_decodes.size() == 0) begin
				$display("%0t: unexpected decode %p", $realtime, got);
				mismatches <= mismatches + 1;
			end else begin
				if (got !== expected_decodes[0]) begin
					$display("%0t: decode mismatch, expected %p, actual %p", $realtime,
						expected_decodes[0], got);
					mismatches <= mismatches + 1;
				end
				void'(expected_decodes.pop_front());
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_idle <= 0;
		end else if (hold_results) begin
			pop <= 1'b0;
		end else if (pop_idle > 0) begin
			pop_idle <= pop_idle - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 14) == 0) begin
			pop_idle <= $urandom_range(1, 12);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int         i;
		logic [15:0] a;
		mismatches = 0;
		results_seen = 0;
		calm = 0;
		hold_results = 0;
		pair_open = 0;
		pair_opcode = '0;
		pair_addr = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, two-word forms, wrapping branches, unknown and shadowed words.
		queue_word(16'h0000, 16'h0000);
		queue_word(16'hFFFE, 16'hFFFF);
		queue_word(16'h0010, 16'h91F0);
		queue_word(16'hAAAA, 16'hFFFF);
		queue_word(16'h0020, 16'h93F0);
		queue_word(16'h0022, 16'h0000);
		queue_word(16'h0030, 16'h95FF);
		queue_word(16'h0032, 16'hFFFF);
		queue_word(16'h0040, 16'h940C);
		queue_word(16'h0042, 16'h940C);
		queue_word(16'hFFFE, 16'hF3FF);
		queue_word(16'h0000, 16'hF7F8);
		queue_word(16'hFFFE, 16'hC7FF);
		queue_word(16'h0002, 16'hD800);
		queue_word(16'h0050, 16'hFFF8);
		queue_word(16'h0052, 16'h8000);
		queue_word(16'h0054, 16'h8200);
		queue_word(16'h0056, 16'hAFFF);
		queue_word(16'h0058, 16'h03FF);
		queue_word(16'h005A, 16'h97FF);
		queue_word(16'h005C, 16'h9598);
		queue_word(16'h005E, 16'h01FF);
		queue_word(16'h0060, 16'h02FF);
		queue_word(16'h0062, 16'hBFFF);
		queue_word(16'h0064, 16'hFFFF);
		wait (pending_words.size() == 0);

		// The receiver holds off while requests keep coming, so the input stalls.
		hold_results = 1;
		for (i = 0; i < 20; i++)
			queue_word(16'($urandom), random_opcode());
		repeat (60) @(posedge clk);
		hold_results = 0;
		wait (pending_words.size() == 0 && expected_decodes.size() == 0);
		repeat (6) @(posedge clk);

		a = 16'($urandom);
		for (i = 0; i < 750; i++) begin
			if (i == 650)
				calm = 1;
			// Mostly sequential fetch addresses, now and then a jump elsewhere.
			a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : a + 16'd2;
			queue_word(a, random_opcode());
			if (i % 50 == 49)
				wait (pending_words.size() < 4);
		end
		wait (pending_words.size() == 0 && !push);
		wait (expected_decodes.size() == 0);
		repeat (10) @(posedge clk);
		$display("Decoded %0d instructions from about 800 program words, stalls on both sides.",
			results_seen);
		if (mismatches == 0 && expected_decodes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/avrd_pkg.sv
rtl/avrd_front.sv
rtl/avrd_queue.sv
rtl/avrd_back.sv
rtl/avr_instruction_decoder_top.sv
tb/tb_top.sv
